FILE: hw/rtl/move_to_front_coder_macros.svh
// Assertion macros for the checker module in mtf_checker.sv.
// Each expects signals named clock and reset in the scope where it is used.
`ifndef MOVE_TO_FRONT_CODER_MACROS_SVH
`define MOVE_TO_FRONT_CODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define MTF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MTF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mtf_pkg.sv
package mtf_pkg;

   // Result for a byte that lies outside the alphabet
   localparam logic [7:0] NO_MATCH_CODE = 8'hFF;

   // Kind of pass that travels down the cell row
   typedef enum logic {
      OP_READ = 1'b0,   // fetch the entry at a given position
      OP_MOVE = 1'b1    // take a byte out of the list and put it at the front
   } wave_op_type;

   // One pass as handed from cell to cell
   typedef struct packed {
      logic        valid;
      wave_op_type op;
      logic [7:0]  sym;     // position for a read, byte for a move
      logic [7:0]  carry;   // entry pushed one place back
      logic [7:0]  data;    // entry read, or position where the byte was found
      logic        done;    // byte already found further up the row
      logic        last;    // put the row back to identity behind this pass
      logic        skip;    // leave every entry as it is
   } wave_type;

endpackage

FILE: hw/rtl/mtf_if.sv
// Input item channel
interface mtf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol_in;
   logic       block_last;

   modport source (output valid, output symbol_in, output block_last, input ready);
   modport sink   (input valid, input symbol_in, input block_last, output ready);
endinterface

// Result item channel
interface mtf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol_out;
   logic       out_last;

   modport source (output valid, output symbol_out, output out_last, input ready);
   modport sink   (input valid, input symbol_out, input out_last, output ready);
endinterface

// Mode register write channel
interface mtf_csr_if;
   logic valid;
   logic ready;
   logic decode_mode;

   modport source (output valid, output decode_mode, input ready);
   modport sink   (input valid, input decode_mode, output ready);
endinterface

FILE: hw/rtl/move_to_front_coder.sv
// Byte move-to-front coder. The recency list lives in a row of ALPHABET_SIZE
// cells, one entry each, and every operation is a pass that steps from cell
// to cell, one cell per clock. Encoding (decode_mode 0) sends one move pass
// down the row; decoding (decode_mode 1) first sends a read pass to fetch
// the entry and then a move pass. One item is in the row at a time.
// A new item is taken as soon as the previous result has been moved to the
// output register, even if it has not yet been taken. An item with
// block_last set returns the list to identity order behind it. A byte outside
// the alphabet returns 255 and leaves the list alone; a position outside it
// is treated as the last position. Write decode_mode only while idle.
module move_to_front_coder #(
   parameter int ALPHABET_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   mtf_req_if.sink     req_port,
   mtf_rsp_if.source   rsp_port,
   mtf_csr_if.sink     csr_port
);

   mtf_pkg::wave_type chain_w [ALPHABET_SIZE + 1];

   // Sequencer and result register
   mtf_ctrl #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port),
      .csr_port (csr_port),
      .head_o   (chain_w[0]),
      .tail_i   (chain_w[ALPHABET_SIZE])
   );

   // Row of list cells
   for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
      mtf_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .wave_i (chain_w[i]),
         .wave_o (chain_w[i + 1])
      );
   end

endmodule

FILE: hw/rtl/mtf_cell.sv
module mtf_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  mtf_pkg::wave_type wave_i,
   output mtf_pkg::wave_type wave_o
);

   localparam logic [7:0] IDX = 8'(CELL_INDEX);

   logic [7:0]        value_ff, value_in;
   mtf_pkg::wave_type wave_ff, wave_in;

   // Work on the passing wave and hand it on
   always_comb begin
      value_in = value_ff;
      wave_in  = wave_i;
      if (wave_i.valid) begin
         unique case (wave_i.op)
            mtf_pkg::OP_READ: begin
               if (wave_i.sym == IDX) begin
                  wave_in.data = value_ff;
               end
            end
            mtf_pkg::OP_MOVE: begin
               if (!wave_i.skip && !wave_i.done) begin
                  // take the pushed entry; stop once the byte itself is met
                  value_in = wave_i.carry;
                  if (value_ff == wave_i.sym) begin
                     wave_in.done = 1'b1;
                     wave_in.data = IDX;
                  end else begin
                     wave_in.carry = value_ff;
                  end
               end
               if (wave_i.last) begin
                  value_in = IDX;
               end
            end
         endcase
      end
   end

   // Hold the entry and the outgoing wave
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= IDX;
         wave_ff  <= '0;
      end else begin
         value_ff <= value_in;
         wave_ff  <= wave_in;
      end
   end

   assign wave_o = wave_ff;

endmodule

FILE: hw/rtl/mtf_ctrl.sv
module mtf_ctrl #(
   parameter int ALPHABET_SIZE = 256
) (
   input  logic              clock,
   input  logic              reset,
   mtf_req_if.sink           req_port,
   mtf_rsp_if.source         rsp_port,
   mtf_csr_if.sink           csr_port,
   output mtf_pkg::wave_type head_o,
   input  mtf_pkg::wave_type tail_i
);

   localparam logic [8:0] SIZE_W   = 9'(ALPHABET_SIZE);
   localparam logic [7:0] LAST_POS = 8'(ALPHABET_SIZE - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_MOVE = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic              mode_ff, mode_in;
   logic              last_ff, last_in;
   logic              skip_ff, skip_in;
   logic [7:0]        res_ff, res_in;
   mtf_pkg::wave_type head_ff, head_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_sym_ff, rsp_sym_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              req_take;
   logic              rsp_free;
   logic              out_of_range;

   assign req_take     = req_port.valid && (state_ff == ST_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_port.ready;
   assign out_of_range = {1'b0, req_port.symbol_in} >= SIZE_W;

   // Sequence the read and move passes of one item
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      last_in      = last_ff;
      skip_in      = skip_ff;
      res_in       = res_ff;
      head_in      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_sym_in   = rsp_sym_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_port.valid) begin
         mode_in = csr_port.decode_mode;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               last_in       = req_port.block_last;
               head_in.valid = 1'b1;
               head_in.last  = req_port.block_last;
               if (mode_ff) begin
                  // fetch the entry first, saturating the position
                  head_in.op  = mtf_pkg::OP_READ;
                  head_in.sym = out_of_range ? LAST_POS : req_port.symbol_in;
                  skip_in     = 1'b0;
                  state_in    = ST_READ;
               end else begin
                  head_in.op    = mtf_pkg::OP_MOVE;
                  head_in.sym   = req_port.symbol_in;
                  head_in.carry = req_port.symbol_in;
                  head_in.skip  = out_of_range;
                  skip_in       = out_of_range;
                  state_in      = ST_MOVE;
               end
            end
         end
         ST_READ: begin
            if (tail_i.valid) begin
               // move the fetched byte to the front
               res_in        = tail_i.data;
               head_in.valid = 1'b1;
               head_in.op    = mtf_pkg::OP_MOVE;
               head_in.sym   = tail_i.data;
               head_in.carry = tail_i.data;
               head_in.last  = last_ff;
               state_in      = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (tail_i.valid) begin
               if (!mode_ff) begin
                  res_in = skip_ff ? mtf_pkg::NO_MATCH_CODE : tail_i.data;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = res_ff;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      skip_ff     <= skip_in;
      res_ff      <= res_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_port.ready      = (state_ff == ST_IDLE);
   assign csr_port.ready      = 1'b1;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.symbol_out = rsp_sym_ff;
   assign rsp_port.out_last   = rsp_last_ff;
   assign head_o              = head_ff;

endmodule

FILE: hw/rtl/mtf_checker.sv
`include "move_to_front_coder_macros.svh"

module mtf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_symbol,
   input logic       rsp_last
);

   // one item at a time: stop taking items straight after one is accepted
   `MTF_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "item taken while busy")

   // a result must pass through the cell row, so none appears right after an item
   `MTF_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready, !$rose(rsp_valid), "result too early")

   // a result is only loaded as the coder returns to idle
   `MTF_ASSERT_SAME(a_load_idle, $rose(rsp_valid), req_ready, "result loaded while busy")

   // hold a stalled result
   `MTF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_symbol) && $stable(rsp_last), "stalled result changed")

endmodule

bind move_to_front_coder mtf_checker u_mtf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_symbol (rsp_port.symbol_out),
   .rsp_last   (rsp_port.out_last)
);
